### rtl/core/mpcb_pkg.sv
// Package for the mid-price candle builder.
// Holds shared constants, opcodes, the control state type and the divider status struct.
// No dependencies.
package mpcb_pkg;

  // Fixed widths of the configuration registers and the tick counter
  localparam int CFG_BITS   = 32;
  localparam int COUNT_BITS = 32;

  // Register indexes on the configuration port
  localparam logic REG_FRAME_LENGTH = 1'b0;
  localparam logic REG_GAP_LIMIT    = 1'b1;

  // Input opcodes and sides
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPDATE,
    S_EMIT
  } mpcb_state_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/mpcb_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Used to split a tick time into bucket number and remainder.
// Depends on mpcb_pkg.
module mpcb_div import mpcb_pkg::*; #(
  parameter int DIVIDEND_BITS = 48,
  parameter int DIVISOR_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic [DIVISOR_BITS-1:0]  remainder,
  output div_stat_t                stat
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [CNT_BITS-1:0]      cnt;
  logic                     busy;
  logic                     done;

  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_BITS-2:0], ge};
      rem <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

`ifndef SYNTHESIS
  // Remainder is always reduced below the divisor when the result is posted
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  // A run lasts exactly one step per dividend bit
  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == CNT_BITS'(1)) |=> (done && !busy))
    else $error("divider did not finish on its last step");
`endif

endmodule

### rtl/core/mid_price_candle_builder_unit.sv
// Top level of the mid-price candle builder.
// Tracks ask/bid, forms mid prices and builds OHLC candles; uses mpcb_pkg and mpcb_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per tick or flush.
//   Output channel (out_valid/out_ready) carries one finished candle per beat.
//   Config port (cfg_we/cfg_addr/cfg_wdata) writes frame_length (index 0) and
//   gap_limit (index 1); frame_length 0 acts as 1.
// Sequencing:
//   A tick that forms a mid price holds in_ready low through the divider launch,
//   the TIME_BITS steps of the bit-serial divider that computes the bucket
//   number, the wait in S_DIV to see it finish and the update in S_UPDATE;
//   the next beat is taken once the sequencer is back in S_IDLE.
//   A tick that leaves either side missing, or a flush with no open candle,
//   is handled in S_IDLE alone. A flush with an open candle also passes
//   through S_EMIT. The output candle is registered from the emit step.
// Reset (rst, synchronous): both sides invalid, no open candle, output empty,
//   registers back to frame_length 60000 and gap_limit 3600000.
// Stall: the output register holds a candle while out_ready is low; the block
//   still takes and processes beats, and only waits when a second candle must
//   be posted while the first has not been taken.
module mid_price_candle_builder_unit import mpcb_pkg::*; #(
  parameter int PRICE_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic                  side,
  input  logic [TIME_BITS-1:0]  tick_time,
  input  logic [PRICE_BITS-1:0] tick_price,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TIME_BITS-1:0]  candle_time,
  output logic [PRICE_BITS:0]   candle_open,
  output logic [PRICE_BITS:0]   candle_high,
  output logic [PRICE_BITS:0]   candle_low,
  output logic [PRICE_BITS:0]   candle_close,
  output logic [COUNT_BITS-1:0] candle_ticks
);

  localparam logic [CFG_BITS-1:0] FRAME_LENGTH_INIT = CFG_BITS'(60000);
  localparam logic [CFG_BITS-1:0] GAP_LIMIT_INIT    = CFG_BITS'(3600000);

  // Configuration registers
  logic [CFG_BITS-1:0] frame_length;
  logic [CFG_BITS-1:0] gap_limit;

  // Quote state
  logic [PRICE_BITS-1:0] ask_price, bid_price;
  logic [TIME_BITS-1:0]  ask_time, bid_time;
  logic                  ask_valid, bid_valid;

  // Open candle
  logic                  candle_active;
  logic [TIME_BITS-1:0]  candle_bucket, candle_start;
  logic [PRICE_BITS:0]   cur_open, cur_high, cur_low, cur_close;
  logic [COUNT_BITS-1:0] cur_count;

  // Captured tick
  logic [TIME_BITS-1:0]  t_q;
  logic [PRICE_BITS:0]   mid_q;

  // Sequencer
  mpcb_state_t state, state_next;
  logic        accept;
  logic        capture_tick, div_start, do_open, do_emit, do_merge, do_close;
  logic        slot_free;

  // Divider
  logic [TIME_BITS-1:0] div_quo;
  logic [CFG_BITS-1:0]  div_rem;
  logic [CFG_BITS-1:0]  divisor;
  div_stat_t            div_stat;

  // Front-end tick evaluation
  logic                  had_ref;
  logic [TIME_BITS-1:0]  ref_time;
  logic                  gap_hit;
  logic                  ask_valid_new, bid_valid_new;
  logic [PRICE_BITS-1:0] ask_price_new, bid_price_new;
  logic [PRICE_BITS:0]   mid_new;
  logic [TIME_BITS-1:0]  start_time;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign divisor   = (frame_length == '0) ? CFG_BITS'(1) : frame_length;

  // Reference time, gap test and the quote state after this tick
  always_comb begin
    had_ref  = ask_valid && bid_valid;
    ref_time = (ask_time > bid_time) ? ask_time : bid_time;
    gap_hit  = had_ref && (tick_time > ref_time) &&
               ((tick_time - ref_time) > TIME_BITS'(gap_limit));
    ask_price_new = (side == SIDE_ASK) ? tick_price : ask_price;
    bid_price_new = (side == SIDE_BID) ? tick_price : bid_price;
    ask_valid_new = ((side == SIDE_ASK) || ask_valid) && !gap_hit;
    bid_valid_new = ((side == SIDE_BID) || bid_valid) && !gap_hit;
    mid_new       = {1'b0, ask_price_new} + {1'b0, bid_price_new};
  end

  // Bucket start is the tick time less its remainder
  assign start_time = t_q - TIME_BITS'(div_rem);

  mpcb_div #(
    .DIVIDEND_BITS (TIME_BITS),
    .DIVISOR_BITS  (CFG_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (t_q),
    .divisor   (divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    capture_tick = 1'b0;
    do_open      = 1'b0;
    do_emit      = 1'b0;
    do_merge     = 1'b0;
    do_close     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op == OP_FLUSH) begin
            if (candle_active) begin
              state_next = S_EMIT;
            end
          end else begin
            capture_tick = 1'b1;
            if (ask_valid_new && bid_valid_new) begin
              state_next = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!candle_active) begin
          do_open    = 1'b1;
          state_next = S_IDLE;
        end else if (div_quo != candle_bucket) begin
          if (slot_free) begin
            do_emit    = 1'b1;
            do_open    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          do_merge   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          do_emit    = 1'b1;
          do_close   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Divider launches the cycle after the tick is captured
  logic div_launch;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_launch <= 1'b0;
    end else begin
      div_launch <= capture_tick && ask_valid_new && bid_valid_new;
    end
  end
  assign div_start = div_launch;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_LENGTH_INIT;
      gap_limit    <= GAP_LIMIT_INIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_LENGTH: frame_length <= cfg_wdata;
        REG_GAP_LIMIT:    gap_limit    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Quote state control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ask_valid <= 1'b0;
      bid_valid <= 1'b0;
    end else if (capture_tick) begin
      ask_valid <= ask_valid_new;
      bid_valid <= bid_valid_new;
    end
  end

  // Quote payload and captured tick
  always_ff @(posedge clk) begin
    if (capture_tick) begin
      t_q   <= tick_time;
      mid_q <= mid_new;
      if (side == SIDE_BID) begin
        bid_price <= tick_price;
        bid_time  <= tick_time;
      end else begin
        ask_price <= tick_price;
        ask_time  <= tick_time;
      end
    end
  end

  // Candle active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      candle_active <= 1'b0;
    end else if (do_open) begin
      candle_active <= 1'b1;
    end else if (do_close) begin
      candle_active <= 1'b0;
    end
  end

  // Candle accumulators
  always_ff @(posedge clk) begin
    if (do_open) begin
      candle_bucket <= div_quo;
      candle_start  <= start_time;
      cur_open      <= mid_q;
      cur_high      <= mid_q;
      cur_low       <= mid_q;
      cur_close     <= mid_q;
      cur_count     <= COUNT_BITS'(1);
    end else if (do_merge) begin
      if (mid_q > cur_high) cur_high <= mid_q;
      if (mid_q < cur_low)  cur_low  <= mid_q;
      cur_close <= mid_q;
      if (cur_count != '1) cur_count <= cur_count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      candle_time  <= candle_start;
      candle_open  <= cur_open;
      candle_high  <= cur_high;
      candle_low   <= cur_low;
      candle_close <= cur_close;
      candle_ticks <= cur_count;
    end
  end

`ifndef SYNTHESIS
  // An open candle keeps open and close inside its high/low range
  a_ohlc_order: assert property (@(posedge clk) disable iff (rst)
    candle_active |-> (cur_low <= cur_open && cur_open <= cur_high &&
                       cur_low <= cur_close && cur_close <= cur_high))
    else $error("candle prices out of high/low range");

  // An open candle has counted at least one mid price
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    candle_active |-> (cur_count != '0))
    else $error("open candle with zero tick count");

  // The divider only runs for a tick that saw both sides
  a_div_needs_quotes: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (ask_valid && bid_valid))
    else $error("division started without both quotes");

  // The divider reports completion only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // A posted candle is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !do_emit)
    else $error("output candle overwritten while stalled");
`endif

endmodule
